// ----- rtl/csim_pkg.sv -----
// constants and widths shared by the curve similarity scorer
// no dependencies; imported by the top level and its checker
package csim_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_LEN     = 1024;
  localparam int ADDR_W      = $clog2(MAX_LEN);
  localparam int CNT_W       = ADDR_W + 1;
  // sum of one curve, mean dividend with rounding term
  localparam int SUM_W       = SAMPLE_BITS + ADDR_W;
  localparam int DVD_W       = SUM_W + 1;
  localparam int REM_W       = CNT_W + 1;
  localparam int DIV_CNT_W   = $clog2(DVD_W);
  // deviations, products and accumulators
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int ACC_W       = 2 * SAMPLE_BITS + ADDR_W;
  localparam int CROSS_W     = ACC_W + 1;
  localparam int MUL_R_W     = CROSS_W;
  localparam int WIDE_W      = 104;
  // score
  localparam int SCORE_W     = 7;
  localparam int SCORE_MAX   = 100;
  localparam int SCALE_K     = 40000;
  localparam int ODATA_W     = 8;

  localparam logic MODE_CORR = 1'b0;
  localparam logic MODE_DIST = 1'b1;

  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_DEGEN = 1'b1;

endpackage

// ----- rtl/curve_similarity_scorer.sv -----
// curve similarity scorer: loads two curves, scores by correlation or rms distance
// depends on csim_pkg and csim_ram
//
// usage
//   input stream: one word per curve index. tdata carries the reference and
//   candidate samples, tuser says which of them are present, tlast closes the
//   pair and starts scoring. each curve keeps at most 1024 samples.
//   output stream: one word per closed pair, score 0..100 in tdata and the
//   degenerate flag in tuser (score 0: empty curve, or correlation zero variance).
//   cfg_we_i writes score_mode (0 correlation, 1 rms distance); users write it
//   only while idle, as the block does not enforce this.
//   a word without tlast is stored while idle. scoring walks the stores through
//   one read port each with a shared small multiplier and a shift-add multiplier:
//   correlation sums both curves, divides for the rounded means, accumulates
//   deviation products, multiplies and searches; distance accumulates squared
//   differences, multiplies and searches. the input is not ready while scoring.
// reset and stall
//   reset empties both curves and sets mode 0. the score sits in an output
//   register; a stalled receiver holds the next finished score back, and the input.
module curve_similarity_scorer
  import csim_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // config
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,     // score_mode
  // input words
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [31:0]        s_axis_tdata_i,  // ref_sample [15:0], cand_sample [31:16]
  input  logic [1:0]         s_axis_tuser_i,  // ref_present [0], cand_present [1]
  input  logic               s_axis_tlast_i,  // last
  // result words
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [ODATA_W-1:0] m_axis_tdata_o,  // score [6:0], zero [7]
  output logic               m_axis_tuser_o   // status
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM_RD, ST_SUM_ACC, ST_DIV_INIT, ST_DIV,
    ST_P2_RD, ST_P2_DIFF, ST_P2_SQX, ST_P2_SQY, ST_P2_XY, ST_P2_ACC,
    ST_MUL, ST_SRCH_INIT, ST_SRCH, ST_DONE
  } state_e;

  typedef enum logic [1:0] {PH_CSQ, PH_L40K, PH_AB} mul_ph_e;

  state_e  state_q;
  mul_ph_e ph_q;

  logic                   mode_q;
  logic [CNT_W-1:0]       rcnt_q, ccnt_q, idx_q;
  logic [SUM_W-1:0]       sx_q, sy_q;
  logic [SAMPLE_BITS-1:0] mx_q, my_q;
  logic                   div_sel_q;
  logic [DVD_W-1:0]       dvd_q;
  logic [REM_W-1:0]       rem_q;
  logic [DIV_CNT_W-1:0]   dcnt_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]       a_q, b_q;
  logic signed [CROSS_W-1:0] c_q;
  logic [WIDE_W-1:0]      mm_q, macc_q, l_q, p_q, r_q, t_q, p8_q;
  logic [MUL_R_W-1:0]     mr_q;
  logic [SCORE_W-1:0]     k_q;
  logic [SCORE_W-1:0]     res_score_q, score_q;
  logic                   res_stat_q, status_q, out_valid_q;

  // input handshake and store writes
  logic s_acc, r_we, c_we;
  logic [CNT_W-1:0] rcnt_nx, ccnt_nx;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign r_we   = s_acc && s_axis_tuser_i[0] && (rcnt_q < CNT_W'(MAX_LEN));
  assign c_we   = s_acc && s_axis_tuser_i[1] && (ccnt_q < CNT_W'(MAX_LEN));
  assign rcnt_nx = rcnt_q + CNT_W'(r_we);
  assign ccnt_nx = ccnt_q + CNT_W'(c_we);

  logic [SAMPLE_BITS-1:0] rd_x, rd_y;

  csim_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LEN)) u_ref_ram (
    .clk_i, .we_i(r_we), .waddr_i(rcnt_q[ADDR_W-1:0]),
    .wdata_i(s_axis_tdata_i[SAMPLE_BITS-1:0]),
    .raddr_i(idx_q[ADDR_W-1:0]), .rdata_o(rd_x)
  );

  csim_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LEN)) u_cand_ram (
    .clk_i, .we_i(c_we), .waddr_i(ccnt_q[ADDR_W-1:0]),
    .wdata_i(s_axis_tdata_i[16 +: SAMPLE_BITS]),
    .raddr_i(idx_q[ADDR_W-1:0]), .rdata_o(rd_y)
  );

  // lengths and index step
  logic [CNT_W-1:0] max_len, min_len, idx_nx;
  assign max_len = (rcnt_q > ccnt_q) ? rcnt_q : ccnt_q;
  assign min_len = (rcnt_q < ccnt_q) ? rcnt_q : ccnt_q;
  assign idx_nx  = idx_q + CNT_W'(1);

  // restoring divider step
  logic [CNT_W-1:0] divisor;
  logic [REM_W-1:0] rem_t;
  logic             div_ge;
  assign divisor = div_sel_q ? ccnt_q : rcnt_q;
  assign rem_t   = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
  assign div_ge  = rem_t >= REM_W'(divisor);

  // shared small multiplier operands
  logic signed [DIFF_W-1:0] op_a, op_b;
  always_comb begin
    op_a = dx_q;
    op_b = dx_q;
    case (state_q)
      ST_P2_SQY: begin
        op_a = dy_q;
        op_b = dy_q;
      end
      ST_P2_XY: op_b = dy_q;
      default: ;
    endcase
  end

  // deviation of the current samples
  logic signed [DIFF_W-1:0] dev_x, dev_y;
  always_comb begin
    if (mode_q == MODE_DIST) begin
      dev_x = $signed({1'b0, rd_x}) - $signed({1'b0, rd_y});
    end else begin
      dev_x = $signed({1'b0, rd_x}) - $signed({1'b0, mx_q});
    end
    dev_y = $signed({1'b0, rd_y}) - $signed({1'b0, my_q});
  end

  logic [CROSS_W-1:0] c_abs;
  assign c_abs = c_q[CROSS_W-1] ? CROSS_W'(-c_q) : CROSS_W'(c_q);

  logic [ACC_W-1:0] prod_u;
  assign prod_u = ACC_W'(unsigned'(prod_q));

  logic l_ge_r;
  assign l_ge_r = l_q >= r_q;

  // sequencer, datapath registers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_CSQ;
      mode_q      <= MODE_CORR;
      rcnt_q      <= '0;
      ccnt_q      <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      div_sel_q   <= 1'b0;
      dcnt_q      <= '0;
      k_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (out_valid_q && m_axis_tready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      prod_q <= op_a * op_b;
      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            rcnt_q <= rcnt_nx;
            ccnt_q <= ccnt_nx;
            idx_q  <= '0;
            sx_q   <= '0;
            sy_q   <= '0;
            a_q    <= '0;
            b_q    <= '0;
            c_q    <= '0;
            if (s_axis_tlast_i) begin
              if (rcnt_nx == '0 || ccnt_nx == '0) begin
                res_score_q <= '0;
                res_stat_q  <= STAT_DEGEN;
                state_q     <= ST_DONE;
              end else if (mode_q == MODE_DIST) begin
                state_q <= ST_P2_RD;
              end else begin
                state_q <= ST_SUM_RD;
              end
            end
          end
        end
        ST_SUM_RD: state_q <= ST_SUM_ACC;
        ST_SUM_ACC: begin
          if (idx_q < rcnt_q) sx_q <= sx_q + SUM_W'(rd_x);
          if (idx_q < ccnt_q) sy_q <= sy_q + SUM_W'(rd_y);
          idx_q <= idx_nx;
          if (idx_nx == max_len) begin
            div_sel_q <= 1'b0;
            state_q   <= ST_DIV_INIT;
          end else begin
            state_q <= ST_SUM_RD;
          end
        end
        ST_DIV_INIT: begin
          // rounded mean: (sum + len/2) / len
          dvd_q  <= div_sel_q ? DVD_W'(sy_q) + DVD_W'(ccnt_q >> 1)
                              : DVD_W'(sx_q) + DVD_W'(rcnt_q >> 1);
          rem_q  <= '0;
          dcnt_q <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q  <= div_ge ? rem_t - REM_W'(divisor) : rem_t;
          dvd_q  <= {dvd_q[DVD_W-2:0], div_ge};
          dcnt_q <= dcnt_q + DIV_CNT_W'(1);
          if (dcnt_q == DIV_CNT_W'(DVD_W - 1)) begin
            if (!div_sel_q) begin
              mx_q      <= {dvd_q[SAMPLE_BITS-2:0], div_ge};
              div_sel_q <= 1'b1;
              state_q   <= ST_DIV_INIT;
            end else begin
              my_q    <= {dvd_q[SAMPLE_BITS-2:0], div_ge};
              idx_q   <= '0;
              state_q <= ST_P2_RD;
            end
          end
        end
        ST_P2_RD: state_q <= ST_P2_DIFF;
        ST_P2_DIFF: begin
          dx_q    <= dev_x;
          dy_q    <= dev_y;
          state_q <= ST_P2_SQX;
        end
        ST_P2_SQX: state_q <= (mode_q == MODE_DIST) ? ST_P2_ACC : ST_P2_SQY;
        ST_P2_SQY: begin
          a_q     <= a_q + prod_u;
          state_q <= ST_P2_XY;
        end
        ST_P2_XY: begin
          b_q     <= b_q + prod_u;
          state_q <= ST_P2_ACC;
        end
        ST_P2_ACC: begin
          if (mode_q == MODE_DIST) begin
            a_q <= a_q + prod_u;
          end else begin
            c_q <= c_q + CROSS_W'(prod_q);
          end
          idx_q <= idx_nx;
          if (idx_nx != min_len) begin
            state_q <= ST_P2_RD;
          end else if (mode_q == MODE_DIST) begin
            // a holds the last square only after this cycle
            mm_q    <= WIDE_W'(a_q + prod_u);
            mr_q    <= MUL_R_W'(SCALE_K);
            macc_q  <= '0;
            p_q     <= WIDE_W'(rcnt_q) << (2 * SAMPLE_BITS);
            ph_q    <= PH_L40K;
            state_q <= ST_MUL;
          end else begin
            ph_q    <= PH_CSQ;
            state_q <= ST_MUL;
            mr_q    <= '0;
            macc_q  <= '0;
          end
        end
        ST_MUL: begin
          if (ph_q == PH_CSQ && mr_q == '0 && macc_q == '0 && k_q == '0) begin
            // first visit after correlation sums: check degenerate, load c*c
            if (a_q == '0 || b_q == '0) begin
              res_score_q <= '0;
              res_stat_q  <= STAT_DEGEN;
              state_q     <= ST_DONE;
            end else begin
              mm_q <= WIDE_W'(c_abs);
              mr_q <= c_abs;
              k_q  <= SCORE_W'(1);
            end
          end else if (mr_q != '0) begin
            if (mr_q[0]) macc_q <= macc_q + mm_q;
            mm_q <= mm_q << 1;
            mr_q <= mr_q >> 1;
          end else begin
            macc_q <= '0;
            case (ph_q)
              PH_CSQ: begin
                mm_q <= macc_q;
                mr_q <= MUL_R_W'(SCALE_K);
                ph_q <= PH_L40K;
              end
              PH_L40K: begin
                l_q <= macc_q;
                if (mode_q == MODE_DIST) begin
                  state_q <= ST_SRCH_INIT;
                end else begin
                  mm_q <= WIDE_W'(a_q);
                  mr_q <= MUL_R_W'(b_q);
                  ph_q <= PH_AB;
                end
              end
              PH_AB: begin
                p_q     <= macc_q;
                state_q <= ST_SRCH_INIT;
              end
              default: state_q <= ST_SRCH_INIT;
            endcase
          end
        end
        ST_SRCH_INIT: begin
          // walk odd squares (2t-1)^2 * p, t = 1..100
          r_q     <= p_q;
          t_q     <= p_q << 3;
          p8_q    <= p_q << 3;
          k_q     <= SCORE_W'(1);
          state_q <= ST_SRCH;
        end
        ST_SRCH: begin
          if (mode_q == MODE_CORR) begin
            if (!l_ge_r) begin
              res_score_q <= k_q - SCORE_W'(1);
              res_stat_q  <= STAT_OK;
              state_q     <= ST_DONE;
            end else if (k_q == SCORE_W'(SCORE_MAX)) begin
              res_score_q <= SCORE_W'(SCORE_MAX);
              res_stat_q  <= STAT_OK;
              state_q     <= ST_DONE;
            end
          end else begin
            if (r_q >= l_q) begin
              res_score_q <= SCORE_W'(SCORE_MAX + 1) - k_q;
              res_stat_q  <= STAT_OK;
              state_q     <= ST_DONE;
            end else if (k_q == SCORE_W'(SCORE_MAX)) begin
              res_score_q <= '0;
              res_stat_q  <= STAT_OK;
              state_q     <= ST_DONE;
            end
          end
          r_q <= r_q + t_q;
          t_q <= t_q + p8_q;
          k_q <= k_q + SCORE_W'(1);
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready_i) begin
            score_q     <= res_score_q;
            status_q    <= res_stat_q;
            out_valid_q <= 1'b1;
            rcnt_q      <= '0;
            ccnt_q      <= '0;
            k_q         <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, score_q};
  assign m_axis_tuser_o  = status_q;

endmodule

// ----- rtl/csim_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module csim_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/csim_chk.sv -----
// port-level checker for the curve similarity scorer, bound to the top level
// depends on csim_pkg
module csim_chk
  import csim_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic               s_axis_tlast_i,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [ODATA_W-1:0] m_axis_tdata_o,
  input logic               m_axis_tuser_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o &&
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result word changed while stalled");

  // closing word starts scoring, input stops
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input ready right after closing word");

  // degenerate result carries score zero
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("degenerate result with nonzero score");

  // score in range
  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o <= ODATA_W'(SCORE_MAX))
    else $error("score out of range");

endmodule

bind curve_similarity_scorer csim_chk u_csim_chk (.*);

// ----- sim/testbench.sv -----
// self-checking testbench for curve_similarity_scorer: directed and random curve pairs
// in both score modes, with a built-in score predictor checked against every result word
// depends on csim_pkg and the rtl of curve_similarity_scorer
module testbench;
  import csim_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] ref_sample;
    logic                   ref_present;
    logic [SAMPLE_BITS-1:0] cand_sample;
    logic                   cand_present;
    logic                   last;
  } pair_word_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               status;
  } score_word_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_wdata_i;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [31:0]        s_axis_tdata_i;   // ref_sample [15:0], cand_sample [31:16]
  logic [1:0]         s_axis_tuser_i;   // ref_present [0], cand_present [1]
  logic               s_axis_tlast_i;   // last
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [ODATA_W-1:0] m_axis_tdata_o;   // score [6:0], zero [7]
  logic               m_axis_tuser_o;   // status

  curve_similarity_scorer dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .s_axis_tlast_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  // predictor state
  logic [SAMPLE_BITS-1:0] ref_curve  [MAX_LEN];
  logic [SAMPLE_BITS-1:0] cand_curve [MAX_LEN];
  int unsigned            ref_len;
  int unsigned            cand_len;
  logic                   mode_q;

  pair_word_t  pending_words [$];
  score_word_t expected_scores [$];
  pair_word_t  cur_word;
  logic        in_fire;
  int          send_gap;
  int          recv_stall;
  bit          idle_on;
  int          errors;
  int unsigned cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // pick an idle length: mostly short, a few long
  function automatic int pick_gap();
    if (!idle_on) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // correlation score, largest k with 40000*c^2 >= (2k-1)^2*a*b
  function automatic score_word_t corr_score();
    longint unsigned sx, sy, a, b;
    longint          mx, my, dx, dy, c;
    logic [127:0]    lhs, rhs;
    int unsigned     m;
    score_word_t     res;
    sx = 0; sy = 0; a = 0; b = 0; c = 0;
    m = (ref_len < cand_len) ? ref_len : cand_len;
    for (int i = 0; i < ref_len; i++) sx += ref_curve[i];
    for (int i = 0; i < cand_len; i++) sy += cand_curve[i];
    mx = longint'((sx + ref_len / 2) / ref_len);
    my = longint'((sy + cand_len / 2) / cand_len);
    for (int i = 0; i < m; i++) begin
      dx = longint'(ref_curve[i]) - mx;
      dy = longint'(cand_curve[i]) - my;
      a += dx * dx;
      b += dy * dy;
      c += dx * dy;
    end
    res.score = '0;
    res.status = STAT_DEGEN;
    if (a == 0 || b == 0) return res;
    if (c < 0) c = -c;
    res.status = STAT_OK;
    lhs = 128'(c) * 128'(c) * 128'(SCALE_K);
    for (int k = 1; k <= SCORE_MAX; k++) begin
      rhs = 128'(a) * 128'(b) * 128'((2 * k - 1) * (2 * k - 1));
      if (lhs >= rhs) res.score = SCORE_W'(k);
    end
    return res;
  endfunction

  // distance score, count of k with 40000*d <= (201-2k)^2 * nx * 2^32
  function automatic score_word_t dist_score();
    longint unsigned d;
    longint          df;
    logic [127:0]    lhs, rhs;
    int unsigned     m;
    score_word_t     res;
    d = 0;
    m = (ref_len < cand_len) ? ref_len : cand_len;
    for (int i = 0; i < m; i++) begin
      df = longint'(ref_curve[i]) - longint'(cand_curve[i]);
      d += df * df;
    end
    lhs = 128'(d) * 128'(SCALE_K);
    res.score = '0;
    res.status = STAT_OK;
    for (int k = 1; k <= SCORE_MAX; k++) begin
      rhs = (128'((201 - 2 * k) * (201 - 2 * k)) * 128'(ref_len)) << (2 * SAMPLE_BITS);
      if (rhs >= lhs) res.score = SCORE_W'(k);
    end
    return res;
  endfunction

  // append one accepted word and score the pair on last
  function automatic void absorb_word(pair_word_t w);
    score_word_t res;
    if (w.ref_present && ref_len < MAX_LEN) begin
      ref_curve[ref_len] = w.ref_sample;
      ref_len++;
    end
    if (w.cand_present && cand_len < MAX_LEN) begin
      cand_curve[cand_len] = w.cand_sample;
      cand_len++;
    end
    if (!w.last) return;
    if (ref_len == 0 || cand_len == 0) begin
      res.score = '0;
      res.status = STAT_DEGEN;
    end else if (mode_q == MODE_CORR) begin
      res = corr_score();
    end else begin
      res = dist_score();
    end
    expected_scores.push_back(res);
    ref_len = 0;
    cand_len = 0;
  endfunction

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && !in_fire) begin
        // hold the word until taken
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_words.size() > 0) begin
        cur_word = pending_words.pop_front();
        s_axis_tdata_i <= {cur_word.cand_sample, cur_word.ref_sample};
        s_axis_tuser_i <= {cur_word.cand_present, cur_word.ref_present};
        s_axis_tlast_i <= cur_word.last;
        s_axis_tvalid_i <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      recv_stall <= pick_gap();
    end
  end

  // input acceptance feeds the predictor
  always @(posedge clk_i) begin
    in_fire <= s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      absorb_word('{ref_sample: s_axis_tdata_i[15:0], ref_present: s_axis_tuser_i[0],
                    cand_sample: s_axis_tdata_i[31:16], cand_present: s_axis_tuser_i[1],
                    last: s_axis_tlast_i});
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    score_word_t exp_w;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_scores.size() == 0) begin
        $error("unexpected result word: score %0d status %0d",
               m_axis_tdata_o, m_axis_tuser_o);
        errors++;
      end else begin
        exp_w = expected_scores.pop_front();
        if (m_axis_tdata_o !== {1'b0, exp_w.score}) begin
          $error("score: expected %0d, got %0d", exp_w.score, m_axis_tdata_o);
          errors++;
        end
        if (m_axis_tuser_o !== exp_w.status) begin
          $error("status: expected %0d, got %0d", exp_w.status, m_axis_tuser_o);
          errors++;
        end
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_word(int r, bit rp, int c, bit cp, bit l);
    pending_words.push_back('{ref_sample: SAMPLE_BITS'(r), ref_present: rp,
                              cand_sample: SAMPLE_BITS'(c), cand_present: cp, last: l});
  endtask

  // random pair of curves with a random relation between them
  task automatic push_random_pair(int len);
    int flavor, r, c, base;
    bit rp, cp;
    flavor = $urandom_range(0, 4);
    base = $urandom_range(0, 65535);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 65535);
      case (flavor)
        1: c = (r + $urandom_range(0, 2047)) & 16'hffff;
        2: c = 65535 - r;
        3: begin
          r = base;
          c = $urandom_range(0, 65535);
        end
        default: c = $urandom_range(0, 65535);
      endcase
      rp = $urandom_range(0, 9) != 0;
      cp = $urandom_range(0, 9) != 0;
      push_word(r, rp, c, cp, i == len - 1);
    end
  endtask

  // wait for an idle block, then set the mode
  task automatic set_mode(logic m);
    while (pending_words.size() > 0 || s_axis_tvalid_i || expected_scores.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    mode_q = m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic directed_pairs();
    // full scale extremes, a rising and a falling curve
    push_word(0, 1, 65535, 1, 0);
    push_word(65535, 1, 0, 1, 0);
    push_word(32768, 1, 32768, 1, 1);
    // empty reference, empty candidate, both empty
    push_word(0, 0, 1234, 1, 1);
    push_word(4321, 1, 0, 0, 1);
    push_word(0, 0, 0, 0, 1);
    // constant curve
    push_word(500, 1, 10, 1, 0);
    push_word(500, 1, 20000, 1, 0);
    push_word(500, 1, 65535, 1, 1);
    // unequal lengths
    push_word(100, 1, 100, 1, 0);
    push_word(60000, 1, 60000, 0, 0);
    push_word(3000, 1, 7, 0, 1);
    // identical curves
    push_word(65535, 1, 65535, 1, 0);
    push_word(1, 1, 1, 1, 1);
  endtask

  initial begin
    int len;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = '0;
    s_axis_tlast_i = 1'b0;
    m_axis_tready_i = 1'b0;
    in_fire = 1'b0;
    send_gap = 0;
    recv_stall = 0;
    idle_on = 1'b1;
    errors = 0;
    cycles = 0;
    ref_len = 0;
    cand_len = 0;
    mode_q = MODE_CORR;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed pairs in both modes
    set_mode(MODE_CORR);
    directed_pairs();
    set_mode(MODE_DIST);
    directed_pairs();

    // random pairs, mostly short curves
    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph % 3) != 2;
      set_mode((ph % 2) ? MODE_DIST : MODE_CORR);
      for (int n = 0; n < 100;) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 12);
        push_random_pair(len);
        n += len;
      end
    end

    while (pending_words.size() > 0 || s_axis_tvalid_i || expected_scores.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
